// ===== rtl/core/gbci_pkg.sv =====
// Shared constants, types and arithmetic helpers for the gyro bias and integration block.
`timescale 1ns / 1ps
`default_nettype none

package gbci_pkg;

    // Default calibration length
    localparam int CALIB_SAMPLES_DEF = 20;

    // Field widths
    localparam int RAW_W   = 16;
    localparam int GAIN_W  = 32;
    localparam int PER_W   = 24;
    localparam int OUT_W   = 32;
    localparam int BIAS_W  = 24;
    localparam int DIFF_W  = BIAS_W + 1;
    localparam int OPND_W  = OUT_W + 1;
    localparam int PROD_W  = 2 * OPND_W;
    localparam int EXT_W   = PROD_W + 1;
    localparam int STEP_W  = OUT_W + 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_PERIOD = 2'd2;

    localparam logic [GAIN_W-1:0] RATE_GAIN_RST      = 32'd16777216;
    localparam logic [PER_W-1:0]  SAMPLE_PERIOD_RST  = 24'd16777;
    localparam logic [PER_W-1:0]  INVERSE_PERIOD_RST = 24'd256000;

    // Rounding offsets: half an output LSB before each floor shift
    localparam logic signed [EXT_W-1:0] RND_RATE  = 67'sd32768;
    localparam logic signed [EXT_W-1:0] RND_ACCEL = 67'sd128;
    localparam logic signed [EXT_W-1:0] RND_STEP  = 67'sd16777216;

    localparam int SH_RATE  = 16;
    localparam int SH_ACCEL = 8;
    localparam int SH_STEP  = 25;

    localparam logic signed [EXT_W-1:0] SAT_MAX = 67'sd2147483647;
    localparam logic signed [EXT_W-1:0] SAT_MIN = -67'sd2147483648;

    // Sequencer states
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_DIV   = 8'b00000010,
        ST_BIAS  = 8'b00000100,
        ST_MRATE = 8'b00001000,
        ST_RSAT  = 8'b00010000,
        ST_MACC  = 8'b00100000,
        ST_MSTEP = 8'b01000000,
        ST_FIN   = 8'b10000000
    } seq_state_t;

    // Clamp a wide signed value into 32 bits
    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [EXT_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SAT_MAX)
            r = SAT_MAX[OUT_W-1:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[OUT_W-1:0];
        else
            r = v[OUT_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gyro_bias_calibrate_integrate.sv =====
// Top level of the Z-axis gyro bias calibration and trapezoidal integration block.
`timescale 1ns / 1ps
`default_nettype none

// Each request carries one raw signed 16-bit Z-axis gyro sample (or a restart
// command) and yields exactly one result. The sample is negated with
// saturation. After reset or a restart the block calibrates: it sums
// CALIB_SAMPLES samples, then divides the sum (scaled to Q16.8) by
// CALIB_SAMPLES to form the bias and enters normal mode. In normal mode every
// sample produces a bias-corrected Q16.16 rate, a Q16.16 acceleration from
// the rate difference times the inverse period, and a trapezoidal angle step
// accumulated into a saturating Q16.16 angle. One 33 x 33 signed multiplier
// is shared by the three products in turn under a small sequencer, and the
// same multiplier forms the bias by multiplying the scaled sum by a fixed
// reciprocal of CALIB_SAMPLES. A restart or a calibration request goes from
// idle straight to the finish step; the request that completes calibration
// first takes a reciprocal multiply step and a bias load step; a normal-mode
// sample makes three passes through the shared multiplier, with the rounding
// and saturation steps between them, and updates the angle in the last step.
// in_stall is high while a request is being worked on. The result register
// parts the two sides, so a new request is taken while the previous result
// still waits under out_stall; a finished result waits in the last step
// until the result register frees up. Configuration registers keep their
// values across a restart; the user must write them only while the block is
// idle, which the block itself does not enforce. cfg_ready is always high
// and writes to an index beyond the list are dropped.
module gyro_bias_calibrate_integrate #(
    parameter int CALIB_SAMPLES = gbci_pkg::CALIB_SAMPLES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Request channel
    input  wire logic                                in_valid,
    output      logic                                in_stall,
    input  wire logic                                cmd,
    input  wire logic signed [gbci_pkg::RAW_W-1:0]   raw_rate,
    // Result channel
    output      logic                                out_valid,
    input  wire logic                                out_stall,
    output      logic signed [gbci_pkg::OUT_W-1:0]   angular_rate,
    output      logic signed [gbci_pkg::OUT_W-1:0]   angular_accel,
    output      logic signed [gbci_pkg::OUT_W-1:0]   angle,
    output      logic                                calibrating,
    output      logic                                fresh,
    // Configuration write channel
    input  wire logic                                cfg_valid,
    output      logic                                cfg_ready,
    input  wire logic [gbci_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [gbci_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import gbci_pkg::*;

    // Calibration counter and sum widths follow the sample count
    localparam int CNT_W  = $clog2(CALIB_SAMPLES + 1);
    localparam int SUM_W  = RAW_W + $clog2(CALIB_SAMPLES);
    // Dividend |sum| * 256 with room to spare; always at least BIAS_W bits
    localparam int DIVD_W = SUM_W + 8;
    // Reciprocal ceil(2^RCP_SH / CALIB_SAMPLES); exact floor quotient for any
    // dividend below 2^DIVD_W
    localparam int RCP_SH = DIVD_W + $clog2(CALIB_SAMPLES);
    localparam logic [OPND_W-1:0] RCP_MUL =
        OPND_W'(((64'd1 << RCP_SH) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    seq_state_t                 state_reg, state_next;

    logic [GAIN_W-1:0]          gain_reg;
    logic [PER_W-1:0]           period_reg;
    logic [PER_W-1:0]           inv_period_reg;

    logic                       normal_mode_reg;
    logic [CNT_W-1:0]           calib_count_reg;
    logic signed [SUM_W-1:0]    calib_sum_reg;
    logic signed [BIAS_W-1:0]   bias_reg;
    logic signed [OUT_W-1:0]    prev_rate_reg;
    logic signed [OUT_W-1:0]    angle_acc_reg;
    logic signed [OUT_W-1:0]    last_accel_reg;

    // Working registers of the sequencer
    logic                       item_fresh_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [OUT_W-1:0]    rate_reg;
    logic signed [OUT_W-1:0]    accel_reg;

    // Bias division operands
    logic [DIVD_W-1:0]          divd_reg;
    logic                       neg_reg;

    // Result register
    logic                       out_valid_reg;
    logic signed [OUT_W-1:0]    angular_rate_reg;
    logic signed [OUT_W-1:0]    angular_accel_reg;
    logic signed [OUT_W-1:0]    angle_reg;
    logic                       calibrating_reg;
    logic                       fresh_reg;

    // ------------------------------------------------------------------
    // Combinational datapath
    // ------------------------------------------------------------------
    logic                       in_take;
    logic                       out_room;
    logic                       calib_done;
    logic signed [RAW_W-1:0]    sample;
    logic signed [SUM_W-1:0]    sum_new;
    logic [SUM_W-1:0]           sum_mag;
    logic signed [DIFF_W-1:0]   diff_next;
    logic [BIAS_W-1:0]          bias_mag;
    logic signed [OPND_W-1:0]   mul_a;
    logic signed [OPND_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [EXT_W-1:0]    prod_ext;
    logic signed [EXT_W-1:0]    rate_shift;
    logic signed [EXT_W-1:0]    accel_shift;
    logic signed [EXT_W-1:0]    step_shift;
    logic signed [STEP_W-1:0]   step_val;
    logic signed [EXT_W-1:0]    angle_sum;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_room  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // Negate the raw sample; the most negative code clamps to the most positive
    assign sample = (raw_rate == {1'b1, {(RAW_W-1){1'b0}}}) ?
                    {1'b0, {(RAW_W-1){1'b1}}} : -raw_rate;

    assign sum_new    = calib_sum_reg + {{(SUM_W-RAW_W){sample[RAW_W-1]}}, sample};
    assign sum_mag    = sum_new[SUM_W-1] ? -sum_new : sum_new;
    assign calib_done = (calib_count_reg == CNT_W'(CALIB_SAMPLES - 1));

    // Bias-corrected sample in Q16.8
    assign diff_next = {sample[RAW_W-1], sample, 8'h00} - {bias_reg[BIAS_W-1], bias_reg};

    // Quotient magnitude from the reciprocal product
    assign bias_mag = prod_reg[RCP_SH +: BIAS_W];

    // Shared multiplier: pick operands by sequencer step. Keep the angle-step
    // operands through ST_FIN so its product stays put while the result waits.
    always_comb
    begin
        mul_a = {{(OPND_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};
        mul_b = {1'b0, gain_reg};
        case (state_reg)
            ST_DIV:
            begin
                mul_a = {{(OPND_W-DIVD_W){1'b0}}, divd_reg};
                mul_b = RCP_MUL;
            end
            ST_MACC:
            begin
                mul_a = {rate_reg[OUT_W-1], rate_reg} - {prev_rate_reg[OUT_W-1], prev_rate_reg};
                mul_b = {{(OPND_W-PER_W){1'b0}}, inv_period_reg};
            end
            ST_MSTEP, ST_FIN:
            begin
                mul_a = {rate_reg[OUT_W-1], rate_reg} + {prev_rate_reg[OUT_W-1], prev_rate_reg};
                mul_b = {{(OPND_W-PER_W){1'b0}}, period_reg};
            end
            default:
            begin
                mul_a = {{(OPND_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};
                mul_b = {1'b0, gain_reg};
            end
        endcase
    end

    assign mul_p       = mul_a * mul_b;
    assign prod_ext    = {prod_reg[PROD_W-1], prod_reg};
    assign rate_shift  = (prod_ext + RND_RATE) >>> SH_RATE;
    assign accel_shift = (prod_ext + RND_ACCEL) >>> SH_ACCEL;
    assign step_shift  = (prod_ext + RND_STEP) >>> SH_STEP;
    assign step_val    = step_shift[STEP_W-1:0];
    assign angle_sum   = {{(EXT_W-OUT_W){angle_acc_reg[OUT_W-1]}}, angle_acc_reg}
                       + {{(EXT_W-STEP_W){step_val[STEP_W-1]}}, step_val};

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (cmd || !normal_mode_reg)
                        state_next = (!cmd && calib_done) ? ST_DIV : ST_FIN;
                    else
                        state_next = ST_MRATE;
                end
            end
            ST_DIV:   state_next = ST_BIAS;
            ST_BIAS:  state_next = ST_FIN;
            ST_MRATE: state_next = ST_RSAT;
            ST_RSAT:  state_next = ST_MACC;
            ST_MACC:  state_next = ST_MSTEP;
            ST_MSTEP: state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_room)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            gain_reg        <= RATE_GAIN_RST;
            period_reg      <= SAMPLE_PERIOD_RST;
            inv_period_reg  <= INVERSE_PERIOD_RST;
            normal_mode_reg <= 1'b0;
            calib_count_reg <= '0;
            calib_sum_reg   <= '0;
            bias_reg        <= '0;
            prev_rate_reg   <= '0;
            angle_acc_reg   <= '0;
            last_accel_reg  <= '0;
            item_fresh_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes; drop an index beyond the list
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_RATE_GAIN:      gain_reg       <= cfg_data[GAIN_W-1:0];
                    REG_SAMPLE_PERIOD:  period_reg     <= cfg_data[PER_W-1:0];
                    REG_INVERSE_PERIOD: inv_period_reg <= cfg_data[PER_W-1:0];
                    default:            ;
                endcase
            end

            // Raise valid as a request finishes; drop it once the result is taken
            if (state_reg == ST_FIN && out_room)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        item_fresh_reg <= 1'b0;
                        if (cmd)
                        begin
                            // Restart: clear all state, keep configuration
                            normal_mode_reg <= 1'b0;
                            calib_count_reg <= '0;
                            calib_sum_reg   <= '0;
                            bias_reg        <= '0;
                            prev_rate_reg   <= '0;
                            angle_acc_reg   <= '0;
                            last_accel_reg  <= '0;
                        end
                        else if (!normal_mode_reg)
                        begin
                            if (calib_done)
                            begin
                                calib_count_reg <= '0;
                                calib_sum_reg   <= '0;
                            end
                            else
                            begin
                                calib_count_reg <= calib_count_reg + 1'b1;
                                calib_sum_reg   <= sum_new;
                            end
                        end
                        else
                        begin
                            item_fresh_reg <= 1'b1;
                        end
                    end
                end
                ST_BIAS:
                begin
                    bias_reg        <= neg_reg ? -bias_mag : bias_mag;
                    normal_mode_reg <= 1'b1;
                end
                ST_FIN:
                begin
                    if (out_room && item_fresh_reg)
                    begin
                        prev_rate_reg  <= rate_reg;
                        last_accel_reg <= accel_reg;
                        angle_acc_reg  <= sat32(angle_sum);
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;

        if (in_take)
        begin
            diff_reg <= diff_next;
            // Load |sum| * 256 for the request that completes calibration
            divd_reg <= {sum_mag, 8'h00};
            neg_reg  <= sum_new[SUM_W-1];
        end

        if (state_reg == ST_RSAT)
            rate_reg <= sat32(rate_shift);
        if (state_reg == ST_MSTEP)
            accel_reg <= sat32(accel_shift);

        // Load the result register as the request finishes
        if (state_reg == ST_FIN && out_room)
        begin
            calibrating_reg <= !item_fresh_reg;
            fresh_reg       <= item_fresh_reg;
            if (item_fresh_reg)
            begin
                angular_rate_reg  <= rate_reg;
                angular_accel_reg <= accel_reg;
                angle_reg         <= sat32(angle_sum);
            end
            else
            begin
                angular_rate_reg  <= prev_rate_reg;
                angular_accel_reg <= last_accel_reg;
                angle_reg         <= angle_acc_reg;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign angular_rate  = angular_rate_reg;
    assign angular_accel = angular_accel_reg;
    assign angle         = angle_reg;
    assign calibrating   = calibrating_reg;
    assign fresh         = fresh_reg;

endmodule

`default_nettype wire

// ===== tb/sv/gyro_bias_calibrate_integrate_checker.sv =====
// Scoreboard for the gyro bias block: tracks config, predicts every result and compares it.
`timescale 1ns / 1ps

module gyro_bias_calibrate_integrate_checker #(
    parameter int N_CALIB = gbci_pkg::CALIB_SAMPLES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  cmd,
    input  logic signed [gbci_pkg::RAW_W-1:0]     raw_rate,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic signed [gbci_pkg::OUT_W-1:0]     angular_rate,
    input  logic signed [gbci_pkg::OUT_W-1:0]     angular_accel,
    input  logic signed [gbci_pkg::OUT_W-1:0]     angle,
    input  logic                                  calibrating,
    input  logic                                  fresh,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [gbci_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gbci_pkg::CFG_DATA_W-1:0]       cfg_data,
    output int                                    fail_count
);
    import gbci_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic signed [OUT_W-1:0] rate;
        logic signed [OUT_W-1:0] accel;
        logic signed [OUT_W-1:0] angle;
        logic                    calib;
        logic                    fresh;
    } gyro_result_t;

    // Register copies
    logic [GAIN_W-1:0] gain_q24      = RATE_GAIN_RST;
    logic [PER_W-1:0]  period_q24    = SAMPLE_PERIOD_RST;
    logic [PER_W-1:0]  inv_period_q8 = INVERSE_PERIOD_RST;

    // Tracked block state
    logic                    in_normal      = 1'b0;
    int                      samples_seen   = 0;
    int                      bias_sum       = 0;
    int                      bias_q8        = 0;
    logic signed [OUT_W-1:0] prev_rate_q16  = '0;
    logic signed [OUT_W-1:0] last_accel_q16 = '0;
    logic signed [OUT_W-1:0] angle_q16      = '0;

    gyro_result_t results_due[$];
    int n_waiting = 0;
    int n_bad     = 0;

    // Leftover expectations count as failures too
    assign fail_count = n_bad + n_waiting;

    function automatic longint round_half_up(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp_q16(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[OUT_W-1:0];
    endfunction

    function automatic void clear_track();
        in_normal      = 1'b0;
        samples_seen   = 0;
        bias_sum       = 0;
        bias_q8        = 0;
        prev_rate_q16  = '0;
        last_accel_q16 = '0;
        angle_q16      = '0;
    endfunction

    function automatic gyro_result_t predict_gyro(input logic restart,
                                                  input logic signed [RAW_W-1:0] raw);
        gyro_result_t res;
        int s;
        longint d_q8;
        longint rate_delta;
        longint rate_pair;
        longint step;
        logic signed [OUT_W-1:0] rate;
        res.calib = 1'b0;
        res.fresh = 1'b0;
        // negate; the most negative reading pins to the top of the range
        s = (int'(raw) == -32768) ? 32767 : -int'(raw);
        if (restart) begin
            clear_track();
            res.calib = 1'b1;
        end else if (!in_normal) begin
            res.calib = 1'b1;
            bias_sum += s;
            samples_seen++;
            if (samples_seen >= N_CALIB) begin
                // mean in Q16.8, quotient truncated toward zero
                bias_q8      = int'((longint'(bias_sum) * 256) / N_CALIB);
                in_normal    = 1'b1;
                bias_sum     = 0;
                samples_seen = 0;
            end
        end else begin
            d_q8 = longint'(s) * 256 - longint'(bias_q8);
            rate = clamp_q16(round_half_up(d_q8 * longint'(gain_q24), SH_RATE));
            rate_delta = longint'(rate) - longint'(prev_rate_q16);
            rate_pair  = longint'(rate) + longint'(prev_rate_q16);
            last_accel_q16 =
                clamp_q16(round_half_up(rate_delta * longint'(inv_period_q8), SH_ACCEL));
            step      = round_half_up(rate_pair * longint'(period_q24), SH_STEP);
            angle_q16 = clamp_q16(longint'(angle_q16) + step);
            prev_rate_q16 = rate;
            res.fresh = 1'b1;
        end
        res.rate  = prev_rate_q16;
        res.accel = last_accel_q16;
        res.angle = angle_q16;
        return res;
    endfunction

    task automatic note_mismatch(input string field, input logic signed [OUT_W:0] want,
                                 input logic signed [OUT_W:0] got);
        n_bad++;
        if (n_bad <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        gyro_result_t want;
        if (!rst_n) begin
            gain_q24      = RATE_GAIN_RST;
            period_q24    = SAMPLE_PERIOD_RST;
            inv_period_q8 = INVERSE_PERIOD_RST;
            clear_track();
            results_due.delete();
            n_waiting = 0;
        end else begin
            // a result always belongs to an older request, so retire before adding
            if (out_valid && !out_stall) begin
                if (results_due.size() == 0) begin
                    n_bad++;
                    if (n_bad <= MAX_REPORTS)
                        $display("%0t: result with no request outstanding, rate %0d",
                                 $time, angular_rate);
                end else begin
                    want = results_due.pop_front();
                    n_waiting--;
                    if (angular_rate !== want.rate)
                        note_mismatch("angular_rate", want.rate, angular_rate);
                    if (angular_accel !== want.accel)
                        note_mismatch("angular_accel", want.accel, angular_accel);
                    if (angle !== want.angle)
                        note_mismatch("angle", want.angle, angle);
                    if (calibrating !== want.calib)
                        note_mismatch("calibrating", want.calib, calibrating);
                    if (fresh !== want.fresh)
                        note_mismatch("fresh", want.fresh, fresh);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RATE_GAIN:      gain_q24      = cfg_data;
                    REG_SAMPLE_PERIOD:  period_q24    = cfg_data[PER_W-1:0];
                    REG_INVERSE_PERIOD: inv_period_q8 = cfg_data[PER_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) begin
                results_due.push_back(predict_gyro(cmd, raw_rate));
                n_waiting++;
            end
        end
    end

endmodule

// ===== tb/sv/gyro_bias_calibrate_integrate_tb.sv =====
// Testbench top for the gyro bias calibration and integration block: stimulus and verdict.
`timescale 1ns / 1ps

module gyro_bias_calibrate_integrate_tb;
    import gbci_pkg::*;

    localparam int N_CALIB     = CALIB_SAMPLES_DEF;
    // Cycles with no handshake on any channel before the run is declared hung.
    // The slowest request is a normal-mode sample.
    localparam int STALL_LIMIT = 2000;
    // Quiet cycles after the last result before a register write or the verdict
    localparam int SETTLE      = 40;
    localparam int PHASE_ITEMS = 180;
    localparam int N_PHASES    = 5;
    // Index past the register list; the block must drop writes to it
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic                    cmd       = 1'b0;
    logic signed [RAW_W-1:0] raw_rate  = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [OUT_W-1:0] angular_rate;
    logic signed [OUT_W-1:0] angular_accel;
    logic signed [OUT_W-1:0] angle;
    logic                    calibrating;
    logic                    fresh;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    int   fail_count;
    int   n_sent      = 0;
    int   n_recv      = 0;
    int   idle_cycles = 0;
    // High during the stretch where neither side idles
    logic calm        = 1'b0;

    gyro_bias_calibrate_integrate #(.CALIB_SAMPLES(N_CALIB)) u_top (.*);

    gyro_bias_calibrate_integrate_checker #(.N_CALIB(N_CALIB)) u_check (.*);

    always #5 clk = ~clk;

    // Stall the result side at random with a 9 percent chance, except in the calm stretch
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 9);

    // Count results taken so the stimulus can tell when the block has drained
    always @(posedge clk)
        if (out_valid && !out_stall)
            n_recv <= n_recv + 1;

    // Watchdog: restart the count on any handshake, give up at the limit
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // Clamp an integer into the raw sample range
    function automatic logic signed [RAW_W-1:0] to_raw(input int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[RAW_W-1:0];
    endfunction

    // Full-scale readings: both extremes or any 16-bit pattern
    function automatic logic signed [RAW_W-1:0] wild_sample();
        case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            default: return RAW_W'($urandom());
        endcase
    endfunction

    // Resting gyro: small noise around the drift, now and then a wild reading
    function automatic logic signed [RAW_W-1:0] rest_sample(input int drift);
        if ($urandom_range(0, 19) == 0)
            return wild_sample();
        return to_raw(drift + int'($urandom_range(0, 64)) - 32);
    endfunction

    // Turning gyro: a wider swing around the drift, with some wild readings
    function automatic logic signed [RAW_W-1:0] motion_sample(input int drift);
        if ($urandom_range(0, 99) < 15)
            return wild_sample();
        return to_raw(drift + int'($urandom_range(0, 8192)) - 4096);
    endfunction

    // Present one request and hold it until the block takes it.
    // Idle before it now and then; valid never looks at stall.
    task automatic send_request(input logic restart, input logic signed [RAW_W-1:0] raw);
        while (!calm && $urandom_range(0, 99) < 9) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= restart;
        raw_rate <= raw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_sent++;
    endtask

    // Drop valid, wait for every result to come back, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (n_recv != n_sent)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write one register; leave cfg_valid high so back-to-back writes need one assignment
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Load one register setting per phase, extremes included
    task automatic load_setting(input int phase);
        logic [CFG_DATA_W-1:0] gain;
        logic [CFG_DATA_W-1:0] period;
        logic [CFG_DATA_W-1:0] inv;
        case (phase)
            1: begin
                // all ones; the upper byte of the 24-bit registers must be dropped
                gain   = '1;
                period = '1;
                inv    = '1;
            end
            2: begin
                gain   = '0;
                period = '0;
                inv    = '0;
            end
            3: begin
                gain   = $urandom();
                period = $urandom();
                inv    = $urandom();
            end
            4: begin
                // plausible gains and periods so the outputs mostly stay in range
                gain   = $urandom_range(32'h0040_0000, 32'h0400_0000);
                period = $urandom_range(1000, 60000);
                inv    = $urandom_range(1000, 600000);
            end
            default: begin
                gain   = RATE_GAIN_RST;
                period = SAMPLE_PERIOD_RST;
                inv    = INVERSE_PERIOD_RST;
            end
        endcase
        write_reg(REG_RATE_GAIN, gain);
        write_reg(REG_SAMPLE_PERIOD, period);
        write_reg(REG_INVERSE_PERIOD, inv);
        if (phase == 3)
            write_reg(REG_UNMAPPED, $urandom());
        cfg_valid <= 1'b0;
    endtask

    // One session: restart, calibrate, then track motion.
    // About one in ten is cut short by a restart partway through calibration.
    task automatic run_session();
        int drift;
        int n_cal;
        int n_move;
        int i;
        drift = int'($urandom_range(0, 4000)) - 2000;
        n_cal = ($urandom_range(0, 9) == 0) ? $urandom_range(1, N_CALIB - 1) : N_CALIB;
        send_request(1'b1, RAW_W'($urandom()));
        for (i = 0; i < n_cal; i++)
            send_request(1'b0, rest_sample(drift));
        if (n_cal == N_CALIB) begin
            n_move = $urandom_range(10, 60);
            for (i = 0; i < n_move; i++)
                send_request(1'b0, motion_sample(drift));
        end
    endtask

    initial begin
        int i;
        int p;
        int target;

        // Hold reset at the start, release it once
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_setting(0);

        // Directed: calibrate through the extremes; the minimum checks the
        // saturating negation
        send_request(1'b0, 16'sh8000);
        send_request(1'b0, 16'sh7fff);
        send_request(1'b0, 16'sh0000);
        send_request(1'b0, 16'shffff);
        for (i = 4; i < N_CALIB; i++)
            send_request(1'b0, to_raw(int'($urandom_range(0, 200)) - 100));
        // Normal mode at the extremes, then a restart carrying a junk sample
        send_request(1'b0, 16'sh8000);
        send_request(1'b0, 16'sh7fff);
        send_request(1'b0, 16'sh0000);
        send_request(1'b0, 16'shffff);
        send_request(1'b1, 16'sh5a5a);

        // Random sessions, one register setting per phase; the last runs with no idling
        for (p = 0; p < N_PHASES; p++) begin
            settle();
            load_setting(p);
            calm   <= (p == N_PHASES - 1);
            target = n_sent + PHASE_ITEMS;
            while (n_sent < target)
                run_session();
        end

        settle();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
